FILE: rtl/rdpc_pkg.sv
// Package for the record disk port controller: item types, port and command
// codes, status bits and the buffer geometry. No dependencies.
package rdpc_pkg;

  localparam int RECORD_BYTES = 128;
  localparam int DRIVE_COUNT  = 16;
  localparam int RECORD_COUNT = 16384;

  localparam int IDX_W = $clog2(RECORD_BYTES);
  localparam int BI_W  = $clog2(RECORD_BYTES + 1);

  localparam logic [2:0] OP_PORT_READ  = 3'd0;
  localparam logic [2:0] OP_PORT_WRITE = 3'd1;
  localparam logic [2:0] OP_FILL       = 3'd2;
  localparam logic [2:0] OP_FETCH      = 3'd3;
  localparam logic [2:0] OP_DONE       = 3'd4;
  localparam logic [2:0] OP_IDLE_FLUSH = 3'd5;

  localparam logic [7:0] PORT_CMD    = 8'h10;
  localparam logic [7:0] PORT_DRIVE  = 8'h11;
  localparam logic [7:0] PORT_LBA_LO = 8'h12;
  localparam logic [7:0] PORT_LBA_HI = 8'h13;
  localparam logic [7:0] PORT_DATA   = 8'h14;

  localparam logic [7:0] CMD_CLEAR     = 8'd0;
  localparam logic [7:0] CMD_READ      = 8'd1;
  localparam logic [7:0] CMD_WR_NORMAL = 8'd2;
  localparam logic [7:0] CMD_WR_UNALLOC = 8'd4;
  localparam logic [7:0] CMD_FLUSH     = 8'd5;

  localparam logic [7:0] ST_READY = 8'h01;
  localparam logic [7:0] ST_DATA  = 8'h02;
  localparam logic [7:0] ST_ROOM  = 8'h04;
  localparam logic [7:0] ST_BUSY  = 8'h08;
  localparam logic [7:0] ST_ERROR = 8'h80;

  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_FLUSH = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] port;
    logic [7:0] value;
    logic [6:0] index;
    logic       backend_ok;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [7:0]  status_now;
    logic        request_valid;
    logic [2:0]  request_kind;
    logic [7:0]  request_drive;
    logic [15:0] request_lba;
    logic [7:0]  buffer_byte;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [IDX_W-1:0] raddr;
  } mem_cmd_t;

  typedef struct packed {
    out_item_t item;
    logic      rd_mem;
    logic      bb_mem;
  } stage_t;

endpackage

FILE: rtl/rdpc_buffer.sv
// Record buffer: single write port, one registered read port.
// Depends on rdpc_pkg.
module rdpc_buffer (
  input  logic              clk,
  input  rdpc_pkg::mem_cmd_t cmd,
  input  logic              rd_en,
  output logic [7:0]        rdata
);
  import rdpc_pkg::*;

  logic [7:0] mem [RECORD_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[cmd.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/rdpc_ctrl.sv
// Port and command decoder with the controller's registers; drives the
// buffer access for each item. Depends on rdpc_pkg.
module rdpc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  rdpc_pkg::in_item_t item,
  output rdpc_pkg::mem_cmd_t mem_cmd,
  output rdpc_pkg::stage_t   stage
);
  import rdpc_pkg::*;

  localparam logic [BI_W-1:0] RB_BI  = BI_W'(RECORD_BYTES);
  localparam logic [7:0]      RB_IDX = 8'(RECORD_BYTES);

  logic [7:0]      status_r, status_nxt;
  logic            fatal_r, fatal_nxt;
  logic [7:0]      drive_r, drive_nxt;
  logic [15:0]     lba_r, lba_nxt;
  logic [7:0]      pdrive_r, pdrive_nxt;
  logic [15:0]     plba_r, plba_nxt;
  logic [2:0]      pkind_r, pkind_nxt;
  logic [BI_W-1:0] bi_r, bi_nxt;

  logic            busy, idx_ok, addr_ok, bi_room;
  logic            req_v;
  logic [2:0]      req_k;
  logic [7:0]      req_d;
  logic [15:0]     req_l;
  logic [7:0]      rd_val;
  logic            rd_mem, bb_mem, we;
  logic [IDX_W-1:0] waddr;

  assign busy    = status_r[3];
  assign idx_ok  = {1'b0, item.index} < RB_IDX;
  assign addr_ok = ({1'b0, drive_r} < 9'(DRIVE_COUNT)) && ({1'b0, lba_r} < 17'(RECORD_COUNT));
  assign bi_room = bi_r < RB_BI;

  always_comb begin
    status_nxt = status_r;
    fatal_nxt  = fatal_r;
    drive_nxt  = drive_r;
    lba_nxt    = lba_r;
    pdrive_nxt = pdrive_r;
    plba_nxt   = plba_r;
    pkind_nxt  = pkind_r;
    bi_nxt     = bi_r;
    req_v      = 1'b0;
    req_k      = KIND_READ;
    req_d      = 8'd0;
    req_l      = 16'd0;
    rd_val     = 8'd0;
    rd_mem     = 1'b0;
    bb_mem     = 1'b0;
    we         = 1'b0;
    waddr      = item.index[IDX_W-1:0];
    unique case (item.op)
      OP_PORT_READ: begin
        if (item.port == PORT_CMD) begin
          rd_val = status_r;
        end else if (item.port == PORT_DATA && status_r[1]) begin
          if (bi_room) begin
            rd_mem = 1'b1;
            bi_nxt = bi_r + 1'b1;
            if (bi_nxt >= RB_BI) begin
              status_nxt = ST_READY;
            end
          end else begin
            status_nxt = ST_READY;
          end
        end
      end
      OP_PORT_WRITE: begin
        if (item.port == PORT_CMD) begin
          if (!busy) begin
            if (item.value == CMD_CLEAR) begin
              bi_nxt     = '0;
              status_nxt = ST_READY | (fatal_r ? ST_ERROR : 8'h00);
            end else if (fatal_r) begin
              status_nxt = ST_READY | ST_ERROR;
            end else if (item.value == CMD_FLUSH) begin
              pkind_nxt  = KIND_FLUSH;
              pdrive_nxt = 8'd0;
              plba_nxt   = 16'd0;
              req_v      = 1'b1;
              req_k      = KIND_FLUSH;
              status_nxt = ST_BUSY;
            end else if (!addr_ok) begin
              status_nxt = ST_READY | ST_ERROR;
            end else begin
              bi_nxt = '0;
              if (item.value == CMD_READ) begin
                pkind_nxt  = KIND_READ;
                pdrive_nxt = drive_r;
                plba_nxt   = lba_r;
                req_v      = 1'b1;
                req_k      = KIND_READ;
                req_d      = drive_r;
                req_l      = lba_r;
                status_nxt = ST_BUSY;
              end else if (item.value >= CMD_WR_NORMAL && item.value <= CMD_WR_UNALLOC) begin
                pkind_nxt  = 3'(item.value - 8'd1);
                pdrive_nxt = drive_r;
                plba_nxt   = lba_r;
                status_nxt = ST_READY | ST_ROOM;
              end else begin
                status_nxt = ST_READY | ST_ERROR;
              end
            end
          end
        end else if (!busy) begin
          if (item.port == PORT_DRIVE) begin
            drive_nxt = item.value;
          end else if (item.port == PORT_LBA_LO) begin
            lba_nxt = {lba_r[15:8], item.value};
          end else if (item.port == PORT_LBA_HI) begin
            lba_nxt = {item.value, lba_r[7:0]};
          end else if (item.port == PORT_DATA && status_r[2]) begin
            if (bi_room) begin
              we     = 1'b1;
              waddr  = bi_r[IDX_W-1:0];
              bi_nxt = bi_r + 1'b1;
            end
            if (bi_nxt >= RB_BI) begin
              req_v      = 1'b1;
              req_k      = pkind_r;
              req_d      = pdrive_r;
              req_l      = plba_r;
              status_nxt = ST_BUSY;
            end
          end
        end
      end
      OP_FILL: begin
        if (busy && pkind_r == KIND_READ && idx_ok) begin
          we = 1'b1;
        end
      end
      OP_FETCH: begin
        bb_mem = idx_ok;
      end
      OP_DONE: begin
        if (busy) begin
          if (pkind_r == KIND_READ) begin
            bi_nxt     = '0;
            status_nxt = ST_READY | (item.backend_ok ? ST_DATA : ST_ERROR);
          end else begin
            if (!item.backend_ok) begin
              fatal_nxt = 1'b1;
            end
            status_nxt = ST_READY | (item.backend_ok ? 8'h00 : ST_ERROR);
          end
        end
      end
      OP_IDLE_FLUSH: begin
        if (!busy && !item.backend_ok) begin
          fatal_nxt  = 1'b1;
          status_nxt = ST_READY | ST_ERROR;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_cmd.we    = accept && we;
    mem_cmd.waddr = waddr;
    mem_cmd.wdata = item.value;
    mem_cmd.raddr = (item.op == OP_PORT_READ) ? bi_r[IDX_W-1:0] : item.index[IDX_W-1:0];
    stage.item.read_data     = rd_val;
    stage.item.status_now    = status_nxt;
    stage.item.request_valid = req_v;
    stage.item.request_kind  = req_k;
    stage.item.request_drive = req_d;
    stage.item.request_lba   = req_l;
    stage.item.buffer_byte   = 8'd0;
    stage.rd_mem             = rd_mem;
    stage.bb_mem             = bb_mem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_READY;
      fatal_r  <= 1'b0;
      drive_r  <= 8'd0;
      lba_r    <= 16'd0;
      pdrive_r <= 8'd0;
      plba_r   <= 16'd0;
      pkind_r  <= KIND_READ;
      bi_r     <= '0;
    end else if (accept) begin
      status_r <= status_nxt;
      fatal_r  <= fatal_nxt;
      drive_r  <= drive_nxt;
      lba_r    <= lba_nxt;
      pdrive_r <= pdrive_nxt;
      plba_r   <= plba_nxt;
      pkind_r  <= pkind_nxt;
      bi_r     <= bi_nxt;
    end
  end

endmodule

FILE: rtl/rdpc_ostage.sv
// Result stages: holds each item while the buffer read completes, merges the
// read byte and presents the item on the output register. Depends on rdpc_pkg.
module rdpc_ostage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  rdpc_pkg::stage_t    stage,
  input  logic [7:0]          mem_rdata,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rdpc_pkg::out_item_t out_item
);
  import rdpc_pkg::*;

  stage_t    s1_r;
  logic      s1_valid_r, s1_valid_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, merged;
  logic      s1_move;

  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);

  always_comb begin
    merged = s1_r.item;
    if (s1_r.rd_mem) begin
      merged.read_data = mem_rdata;
    end
    if (s1_r.bb_mem) begin
      merged.buffer_byte = mem_rdata;
    end
    s1_valid_nxt = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= stage;
    end
    if (s1_move) begin
      out_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: rtl/record_disk_port_controller.sv
// Top level of the record disk port controller.
// Depends on rdpc_pkg, rdpc_ctrl, rdpc_buffer and rdpc_ostage.
//
// Usage: every item on the in_ channel is either a CPU port access (read or
// write of the command/status, drive, LBA low/high or data port) or a
// backend event (buffer fill byte, buffer fetch, completion, idle flush).
// Each accepted item yields exactly one item on the out_ channel, carrying
// the port read byte, the status byte after the item, any backend request
// it raises and the buffer byte of a fetch.
// On acceptance the registers are updated, the 128-byte buffer memory is read
// and the item enters the stage register; the output register is then loaded
// with the read byte merged in once it is free, and out_valid rises with it.
// Throughput is one item per cycle while out_ready is high; the single read and
// single write port of the buffer carry all accesses of an item on acceptance.
// After reset the status reads ready only, all address registers are zero
// and the buffer contents are unknown until filled or written.
// When the receiver stalls, one item waits in the output register and a
// second in the stage behind it; in_ready then falls until out_ready returns.
module record_disk_port_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rdpc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rdpc_pkg::out_item_t out_item
);
  import rdpc_pkg::*;

  logic     accept;
  mem_cmd_t mem_cmd;
  stage_t   stage;
  logic [7:0] mem_rdata;

  assign accept = in_valid && in_ready;

  rdpc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_item),
    .mem_cmd (mem_cmd),
    .stage   (stage)
  );

  rdpc_buffer u_buffer (
    .clk   (clk),
    .cmd   (mem_cmd),
    .rd_en (accept),
    .rdata (mem_rdata)
  );

  rdpc_ostage u_ostage (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .stage     (stage),
    .mem_rdata (mem_rdata),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.request_valid |-> out_item.status_now[3])
    else $error("request issued without busy status");

  a_ready_xor_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status_now[0] ^ out_item.status_now[3]))
    else $error("status must be exactly one of ready and busy");

  a_flush_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.request_kind == KIND_FLUSH |->
      out_item.request_drive == 8'd0 && out_item.request_lba == 16'd0)
    else $error("flush request carries a target");

  a_one_byte_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.read_data == 8'd0 || out_item.buffer_byte == 8'd0))
    else $error("read byte and fetch byte both present");

endmodule

FILE: verif/tb_record_disk_port_controller.sv
// Testbench for record_disk_port_controller: directed and random port and backend traffic.
// It predicts each result and checks it on the out_ channel. Needs rdpc_pkg and the RTL.
`timescale 1ns / 100ps

module tb_record_disk_port_controller;
  import rdpc_pkg::*;

  localparam logic [7:0] CMD_WR_DIR    = 8'd3;
  localparam logic [2:0] OP_SPARE_A    = 3'd6;
  localparam logic [2:0] OP_SPARE_B    = 3'd7;
  localparam logic [7:0] PORT_SPARE_LO = 8'h00;
  localparam logic [7:0] PORT_SPARE_HI = 8'hFF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  record_disk_port_controller dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #6 clk = ~clk;

  logic [7:0]  m_status = ST_READY;
  logic        m_fatal = 1'b0;
  logic [7:0]  m_drive = '0;
  logic [15:0] m_lba = '0;
  logic [7:0]  m_pend_drive = '0;
  logic [15:0] m_pend_lba = '0;
  logic [2:0]  m_pend_kind = KIND_READ;
  logic [7:0]  m_index = '0;
  logic [7:0]  m_record [RECORD_BYTES] = '{default: '0};

  out_item_t expected_replies[$];
  int        fail_count = 0;
  int        items_sent = 0;
  int        rx_hold = 0;
  bit        tx_idle = 1'b1;
  bit        rx_idle = 1'b1;
  bit        mix_noise = 1'b0;
  bit        allow_fatal = 1'b0;

  function automatic out_item_t predict_reply(in_item_t it);
    out_item_t r;
    logic      busy;
    r = '0;
    busy = (m_status & ST_BUSY) != 0;
    case (it.op)
      OP_PORT_READ: begin
        if (it.port == PORT_CMD) begin
          r.read_data = m_status;
        end else if (it.port == PORT_DATA && (m_status & ST_DATA) != 0) begin
          if (m_index < RECORD_BYTES) begin
            r.read_data = m_record[m_index[IDX_W-1:0]];
            m_index = m_index + 1'b1;
          end
          if (m_index >= RECORD_BYTES) m_status = ST_READY;
        end
      end
      OP_PORT_WRITE: begin
        if (it.port == PORT_CMD) begin
          if (!busy) begin
            if (it.value == CMD_CLEAR) begin
              m_index = '0;
              m_status = m_fatal ? (ST_READY | ST_ERROR) : ST_READY;
            end else if (m_fatal) begin
              m_status = ST_READY | ST_ERROR;
            end else if (it.value == CMD_FLUSH) begin
              m_pend_kind = KIND_FLUSH;
              m_pend_drive = '0;
              m_pend_lba = '0;
              r.request_valid = 1'b1;
              r.request_kind = KIND_FLUSH;
              m_status = ST_BUSY;
            end else if (m_drive >= DRIVE_COUNT || m_lba >= RECORD_COUNT) begin
              m_status = ST_READY | ST_ERROR;
            end else begin
              m_index = '0;
              if (it.value == CMD_READ) begin
                m_pend_kind = KIND_READ;
                m_pend_drive = m_drive;
                m_pend_lba = m_lba;
                r.request_valid = 1'b1;
                r.request_kind = KIND_READ;
                r.request_drive = m_drive;
                r.request_lba = m_lba;
                m_status = ST_BUSY;
              end else if (it.value >= CMD_WR_NORMAL && it.value <= CMD_WR_UNALLOC) begin
                m_pend_kind = it.value[2:0] - 3'd1;
                m_pend_drive = m_drive;
                m_pend_lba = m_lba;
                m_status = ST_READY | ST_ROOM;
              end else begin
                m_status = ST_READY | ST_ERROR;
              end
            end
          end
        end else if (!busy) begin
          case (it.port)
            PORT_DRIVE:  m_drive = it.value;
            PORT_LBA_LO: m_lba[7:0] = it.value;
            PORT_LBA_HI: m_lba[15:8] = it.value;
            PORT_DATA: begin
              if ((m_status & ST_ROOM) != 0) begin
                if (m_index < RECORD_BYTES) begin
                  m_record[m_index[IDX_W-1:0]] = it.value;
                  m_index = m_index + 1'b1;
                end
                if (m_index >= RECORD_BYTES) begin
                  r.request_valid = 1'b1;
                  r.request_kind = m_pend_kind;
                  r.request_drive = m_pend_drive;
                  r.request_lba = m_pend_lba;
                  m_status = ST_BUSY;
                end
              end
            end
            default: ;
          endcase
        end
      end
      OP_FILL: begin
        if (busy && m_pend_kind == KIND_READ) m_record[it.index] = it.value;
      end
      OP_FETCH: r.buffer_byte = m_record[it.index];
      OP_DONE: begin
        if (busy) begin
          if (m_pend_kind == KIND_READ) begin
            m_index = '0;
            m_status = it.backend_ok ? (ST_READY | ST_DATA) : (ST_READY | ST_ERROR);
          end else begin
            if (!it.backend_ok) m_fatal = 1'b1;
            m_status = it.backend_ok ? ST_READY : (ST_READY | ST_ERROR);
          end
        end
      end
      OP_IDLE_FLUSH: begin
        if (!busy && !it.backend_ok) begin
          m_fatal = 1'b1;
          m_status = ST_READY | ST_ERROR;
        end
      end
      default: ;
    endcase
    r.status_now = m_status;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  initial begin : reply_checker
    int        stall;
    out_item_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 4) : 0;
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_replies.size() == 0) begin
        $error("result with no expectation waiting: %h", out_item);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        check_field("read_data", 16'(want.read_data), 16'(out_item.read_data));
        check_field("status_now", 16'(want.status_now), 16'(out_item.status_now));
        check_field("request_valid", 16'(want.request_valid),
                    16'(out_item.request_valid));
        check_field("request_kind", 16'(want.request_kind), 16'(out_item.request_kind));
        check_field("request_drive", 16'(want.request_drive),
                    16'(out_item.request_drive));
        check_field("request_lba", want.request_lba, out_item.request_lba);
        check_field("buffer_byte", 16'(want.buffer_byte), 16'(out_item.buffer_byte));
      end
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_replies.push_back(predict_reply(it));
    items_sent++;
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t junk_item();
    in_item_t it;
    it.op = 3'($urandom_range(OP_PORT_READ, OP_SPARE_B));
    it.port = 8'($urandom);
    it.value = 8'($urandom);
    it.index = 7'($urandom);
    it.backend_ok = 1'($urandom);
    return it;
  endfunction

  task automatic port_write(input logic [7:0] port, input logic [7:0] value);
    in_item_t it;
    it = junk_item();
    it.op = OP_PORT_WRITE;
    it.port = port;
    it.value = value;
    send_item(it);
  endtask

  task automatic port_read(input logic [7:0] port);
    in_item_t it;
    it = junk_item();
    it.op = OP_PORT_READ;
    it.port = port;
    send_item(it);
  endtask

  task automatic backend_fill(input logic [6:0] index, input logic [7:0] value);
    in_item_t it;
    it = junk_item();
    it.op = OP_FILL;
    it.index = index;
    it.value = value;
    send_item(it);
  endtask

  task automatic backend_fetch(input logic [6:0] index);
    in_item_t it;
    it = junk_item();
    it.op = OP_FETCH;
    it.index = index;
    send_item(it);
  endtask

  task automatic backend_done(input logic ok);
    in_item_t it;
    it = junk_item();
    it.op = OP_DONE;
    it.backend_ok = ok;
    send_item(it);
  endtask

  task automatic idle_flush(input logic ok);
    in_item_t it;
    it = junk_item();
    it.op = OP_IDLE_FLUSH;
    it.backend_ok = ok;
    send_item(it);
  endtask

  task automatic send_noise();
    in_item_t it;
    it = junk_item();
    case ($urandom_range(0, 5))
      0: it.port = PORT_CMD;
      1: it.port = PORT_DRIVE;
      2: it.port = PORT_LBA_LO;
      3: it.port = PORT_LBA_HI;
      4: it.port = PORT_DATA;
      default: ;
    endcase
    if (!allow_fatal && (it.op == OP_DONE || it.op == OP_IDLE_FLUSH)) it.backend_ok = 1'b1;
    send_item(it);
  endtask

  task automatic set_target(input logic [7:0] drive, input logic [15:0] lba);
    port_write(PORT_DRIVE, drive);
    port_write(PORT_LBA_LO, lba[7:0]);
    port_write(PORT_LBA_HI, lba[15:8]);
  endtask

  task automatic random_target();
    logic [7:0]  drive;
    logic [15:0] lba;
    if ($urandom_range(0, 7) == 0) drive = 8'($urandom_range(DRIVE_COUNT, 255));
    else drive = 8'($urandom_range(0, DRIVE_COUNT - 1));
    if ($urandom_range(0, 7) == 0) lba = 16'($urandom_range(RECORD_COUNT, 65535));
    else lba = 16'($urandom_range(0, RECORD_COUNT - 1));
    set_target(drive, lba);
  endtask

  task automatic write_record(input logic [7:0] cmd, input logic ok);
    port_write(PORT_CMD, cmd);
    for (int i = 0; i < RECORD_BYTES; i++) begin
      if (mix_noise && $urandom_range(0, 15) == 0) send_noise();
      port_write(PORT_DATA, 8'($urandom));
    end
    repeat ($urandom_range(1, 4)) backend_fetch(7'($urandom));
    backend_done(ok);
  endtask

  task automatic read_record(input logic ok, input int reads);
    port_write(PORT_CMD, CMD_READ);
    repeat ($urandom_range(0, RECORD_BYTES + 2)) begin
      if (mix_noise && $urandom_range(0, 15) == 0) send_noise();
      backend_fill(7'($urandom), 8'($urandom));
    end
    backend_done(ok);
    port_read(PORT_CMD);
    repeat (reads) port_read(PORT_DATA);
  endtask

  task automatic test_reset_state();
    port_read(PORT_CMD);
    port_read(PORT_DATA);
    port_read(PORT_SPARE_LO);
    port_read(PORT_SPARE_HI);
    port_write(PORT_SPARE_HI, 8'hFF);
    port_write(PORT_DATA, 8'h5A);
    send_item('{op: OP_SPARE_A, port: PORT_CMD, value: 8'hFF, index: 7'h7F, backend_ok: 1'b1});
    send_item('{op: OP_SPARE_B, port: PORT_DATA, value: 8'h00, index: 7'h00, backend_ok: 1'b0});
    backend_done(1'b0);
    backend_fill(7'h00, 8'h11);
    idle_flush(1'b1);
    wait_for_replies();
  endtask

  task automatic test_write_record();
    set_target(8'(DRIVE_COUNT - 1), 16'(RECORD_COUNT - 1));
    port_write(PORT_CMD, CMD_WR_NORMAL);
    port_read(PORT_DATA);
    for (int i = 0; i < RECORD_BYTES; i++) begin
      if (i == 0) port_write(PORT_DATA, 8'h00);
      else if (i == RECORD_BYTES - 1) port_write(PORT_DATA, 8'hFF);
      else port_write(PORT_DATA, 8'($urandom));
    end
    port_write(PORT_DRIVE, 8'h05);
    port_write(PORT_CMD, CMD_CLEAR);
    port_write(PORT_DATA, 8'h01);
    backend_fill(7'h00, 8'hAA);
    backend_fetch(7'h00);
    backend_fetch(7'h7F);
    backend_done(1'b1);
    port_read(PORT_CMD);
    wait_for_replies();
  endtask

  task automatic test_address_checks();
    set_target(8'(DRIVE_COUNT), 16'h0000);
    port_write(PORT_CMD, CMD_READ);
    set_target(8'h00, 16'(RECORD_COUNT));
    port_write(PORT_CMD, CMD_WR_NORMAL);
    set_target(8'hFF, 16'hFFFF);
    port_write(PORT_CMD, CMD_WR_UNALLOC);
    port_write(PORT_CMD, 8'd200);
    port_write(PORT_CMD, CMD_FLUSH);
    idle_flush(1'b0);
    port_write(PORT_CMD, CMD_READ);
    backend_fetch(7'h40);
    backend_done(1'b1);
    set_target(8'h02, 16'h0100);
    port_write(PORT_CMD, 8'd6);
    port_write(PORT_CMD, 8'hFF);
    port_read(PORT_CMD);
    wait_for_replies();
  endtask

  task automatic test_read_record();
    set_target(8'h00, 16'h0000);
    port_write(PORT_CMD, CMD_READ);
    backend_fill(7'h00, 8'h00);
    backend_fill(7'h7F, 8'hFF);
    backend_done(1'b0);
    port_read(PORT_DATA);
    port_write(PORT_CMD, CMD_READ);
    for (int i = 0; i < RECORD_BYTES; i++) backend_fill(7'(i), 8'($urandom));
    backend_done(1'b1);
    port_read(PORT_CMD);
    repeat (RECORD_BYTES + 1) port_read(PORT_DATA);
    port_read(PORT_CMD);
    wait_for_replies();
  endtask

  task automatic test_write_kinds();
    set_target(8'h07, 16'h1234);
    port_write(PORT_CMD, CMD_WR_DIR);
    repeat (10) port_write(PORT_DATA, 8'($urandom));
    port_write(PORT_CMD, CMD_CLEAR);
    port_write(PORT_DATA, 8'h33);
    port_read(PORT_CMD);
    write_record(CMD_WR_DIR, 1'b1);
    set_target(8'h09, 16'h2000);
    write_record(CMD_WR_UNALLOC, 1'b1);
    wait_for_replies();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = 40;
    repeat (30) begin
      port_read(PORT_CMD);
      backend_fetch(7'($urandom));
    end
    wait_for_replies();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    int first;
    int pick;
    first = items_sent;
    mix_noise = 1'b1;
    while (items_sent - first < 250) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if ((m_status & ST_BUSY) != 0) backend_done(1'b1);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        random_target();
        write_record(8'(CMD_WR_NORMAL + $urandom_range(0, 2)), 1'b1);
      end else if (pick < 55) begin
        random_target();
        read_record($urandom_range(0, 5) != 0,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, RECORD_BYTES + 2)
                                                : RECORD_BYTES + 1);
      end else if (pick < 63) begin
        port_write(PORT_CMD, CMD_FLUSH);
        repeat ($urandom_range(0, 3)) backend_fetch(7'($urandom));
        backend_done(1'b1);
      end else if (pick < 80) begin
        repeat ($urandom_range(5, 20)) send_noise();
      end else if (pick < 90) begin
        random_target();
        port_write(PORT_CMD, 8'($urandom));
        port_read(PORT_CMD);
      end else begin
        random_target();
        port_write(PORT_CMD, 8'(CMD_WR_NORMAL + $urandom_range(0, 2)));
        repeat ($urandom_range(1, RECORD_BYTES - 1)) port_write(PORT_DATA, 8'($urandom));
        port_write(PORT_CMD, CMD_CLEAR);
        port_write(PORT_DATA, 8'($urandom));
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    mix_noise = 1'b0;
    wait_for_replies();
  endtask

  task automatic test_fatal();
    if ((m_status & ST_BUSY) != 0) backend_done(1'b1);
    set_target(8'h03, 16'h0064);
    write_record(CMD_WR_DIR, 1'b0);
    port_read(PORT_CMD);
    port_write(PORT_CMD, CMD_READ);
    port_write(PORT_CMD, CMD_FLUSH);
    port_write(PORT_CMD, CMD_CLEAR);
    port_write(PORT_DATA, 8'h77);
    idle_flush(1'b1);
    idle_flush(1'b0);
    backend_done(1'b0);
    allow_fatal = 1'b1;
    repeat (60) send_noise();
    wait_for_replies();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_write_record();
    test_address_checks();
    test_read_record();
    test_write_kinds();
    test_backpressure();
    test_random_traffic();
    test_fatal();
    in_valid <= 1'b0;
    for (int n = 0; n < 2000 && expected_replies.size() != 0; n++) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $error("%0d expected results never arrived", expected_replies.size());
      fail_count++;
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
